>>> hw/rtl/amis_pkg.sv
// ============================================================================
// amis_pkg
// Shared types, widths, opcodes and reset values of the instruction step core.
// ============================================================================
`default_nettype none

package amis_pkg;

    // Field widths of the instruction and result beats.
    localparam int INSTR_W  = 14;
    localparam int OP_W     = 6;
    localparam int BYTE_W   = 8;
    localparam int PC_OUT_W = 13;
    localparam int MADDR_W  = 9;
    localparam int FILE_W   = 7;
    localparam int GOTO_W   = 11;

    // Defaults of the top-level parameters.
    localparam int DATA_DEPTH_DEF = 512;
    localparam int PC_WIDTH_DEF   = 13;

    // Size of one register bank in the data store.
    localparam int BANK_SIZE = 128;

    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Opcodes. Ranges cover the don't-care low opcode bits.
    localparam opcode_t OP_NOP_MOVWF = 6'h00;
    localparam opcode_t OP_CLR       = 6'h01;
    localparam opcode_t OP_ADDWF     = 6'h07;
    localparam opcode_t OP_MOVF      = 6'h08;
    localparam opcode_t OP_BCF_LO    = 6'h10;
    localparam opcode_t OP_BCF_HI    = 6'h13;
    localparam opcode_t OP_BSF_LO    = 6'h14;
    localparam opcode_t OP_BSF_HI    = 6'h17;
    localparam opcode_t OP_GOTO_LO   = 6'h28;
    localparam opcode_t OP_GOTO_HI   = 6'h2F;
    localparam opcode_t OP_MOVLW_LO  = 6'h30;
    localparam opcode_t OP_MOVLW_HI  = 6'h33;

    // Status register layout and reset value.
    localparam int    ST_C      = 0;
    localparam int    ST_DC     = 1;
    localparam int    ST_Z      = 2;
    localparam int    ST_RP_LO  = 5;
    localparam int    ST_RP_HI  = 6;
    localparam byte_t STATUS_RST = 8'h18;

endpackage

`default_nettype wire

>>> hw/rtl/accumulator_mcu_instruction_step_core.sv
// ============================================================================
// accumulator_mcu_instruction_step_core
// Executes one 14-bit instruction per input beat against the W accumulator,
// the status register, the program counter and a banked byte data store, and
// returns one result beat with the new machine state and the store write.
// ----------------------------------------------------------------------------
// In the core, the accepting clock edge launches the read of the banked file
// byte from the synchronous data store into the execute stage; when the
// execute stage fires, that edge commits W, status, PC and the store write and loads the
// result register. A new instruction is accepted every cycle while results
// are taken; a write followed directly by a read of the same byte is served
// by a forwarding register. After reset the core clears the data store, one
// byte per cycle, and accepts no instruction until the clearing pass ends.
// ============================================================================
`default_nettype none

module accumulator_mcu_instruction_step_core #(
    parameter int DATA_DEPTH = amis_pkg::DATA_DEPTH_DEF,
    parameter int PC_WIDTH   = amis_pkg::PC_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [amis_pkg::INSTR_W-1:0]       instr_word,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [amis_pkg::PC_OUT_W-1:0]           next_pc,
    output logic [amis_pkg::BYTE_W-1:0]             w_out,
    output logic [amis_pkg::BYTE_W-1:0]             status_out,
    output logic                                    mem_write,
    output logic [amis_pkg::MADDR_W-1:0]            mem_addr,
    output logic [amis_pkg::BYTE_W-1:0]             mem_data,
    output logic                                    unsupported
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DATA_DEPTH - 1);
    localparam logic [amis_pkg::MADDR_W-1:0] DEPTH_M = amis_pkg::MADDR_W'(DATA_DEPTH);

    // Banked address folded into the store depth. The raw address stays
    // below four times the smallest depth, so three subtractions suffice.
    function automatic logic [ADDR_W-1:0] fold_addr(input logic [amis_pkg::MADDR_W-1:0] raw);
        logic [amis_pkg::MADDR_W-1:0] v;
        v = raw;
        for (int i = 0; i < 3; i++)
        begin
            if (v >= DEPTH_M)
            begin
                v = v - DEPTH_M;
            end
        end
        return v[ADDR_W-1:0];
    endfunction

    // Data store.
    amis_pkg::byte_t mem [DATA_DEPTH];

    // Architectural state.
    amis_pkg::byte_t     w_reg, w_next;
    amis_pkg::byte_t     psw_reg, psw_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;

    // Clearing pass after reset.
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_idx_reg;

    // Execute stage: instruction whose file byte has been read.
    logic                         s1_valid_reg;
    logic [amis_pkg::INSTR_W-1:0] s1_word_reg;
    logic [ADDR_W-1:0]            s1_addr_reg;
    amis_pkg::byte_t              rdata_reg;

    // Last store write, for a read launched on the same edge.
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    amis_pkg::byte_t   fwd_data_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [amis_pkg::PC_OUT_W-1:0] pc_out_reg;
    amis_pkg::byte_t               w_out_reg;
    amis_pkg::byte_t               status_out_reg;
    logic                          wr_out_reg;
    logic [amis_pkg::MADDR_W-1:0]  addr_out_reg;
    amis_pkg::byte_t               data_out_reg;
    logic                          unsup_out_reg;

    logic              accept;
    logic              s1_fire;
    logic [ADDR_W-1:0] rd_addr;

    // Execute-stage decode and results.
    amis_pkg::opcode_t            op;
    logic                         dbit;
    amis_pkg::byte_t              fval;
    amis_pkg::byte_t              bit_mask;
    logic [amis_pkg::BYTE_W:0]    sum;
    logic [4:0]                   low_sum;
    logic [amis_pkg::PC_OUT_W-1:0] goto_ext;
    logic                         wr;
    amis_pkg::byte_t              wdata;
    logic                         unsup;

    // Handshake: the execute stage drains into the result register.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign accept   = in_valid && in_ready;

    // Read address of the incoming beat from the bank bits and file address.
    assign rd_addr = fold_addr({psw_reg[amis_pkg::ST_RP_HI:amis_pkg::ST_RP_LO],
                                instr_word[amis_pkg::FILE_W-1:0]});

    // Byte operand, with the most recent write forwarded over the store.
    assign fval = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rdata_reg;

    assign op       = s1_word_reg[13:8];
    assign dbit     = s1_word_reg[7];
    assign bit_mask = amis_pkg::byte_t'(1) << s1_word_reg[9:7];
    assign sum      = {1'b0, w_reg} + {1'b0, fval};
    assign low_sum  = {1'b0, w_reg[3:0]} + {1'b0, fval[3:0]};
    assign goto_ext = amis_pkg::PC_OUT_W'(s1_word_reg[amis_pkg::GOTO_W-1:0]);

    // Instruction execution.
    always_comb
    begin
        w_next      = w_reg;
        psw_next    = psw_reg;
        pc_next     = pc_reg + PC_WIDTH'(1);
        wr          = 1'b0;
        wdata       = '0;
        unsup       = 1'b0;
        case (op) inside
            amis_pkg::OP_NOP_MOVWF:
            begin
                if (dbit)
                begin
                    wr    = 1'b1;
                    wdata = w_reg;
                end
            end
            amis_pkg::OP_CLR:
            begin
                if (dbit)
                begin
                    wr = 1'b1;
                end
                else
                begin
                    w_next = '0;
                end
                psw_next[amis_pkg::ST_Z] = 1'b1;
            end
            [amis_pkg::OP_MOVLW_LO:amis_pkg::OP_MOVLW_HI]:
            begin
                w_next = s1_word_reg[7:0];
            end
            amis_pkg::OP_ADDWF:
            begin
                psw_next[amis_pkg::ST_C]  = sum[amis_pkg::BYTE_W];
                psw_next[amis_pkg::ST_DC] = low_sum[4];
                psw_next[amis_pkg::ST_Z]  = (sum[amis_pkg::BYTE_W-1:0] == '0);
                if (dbit)
                begin
                    wr    = 1'b1;
                    wdata = sum[amis_pkg::BYTE_W-1:0];
                end
                else
                begin
                    w_next = sum[amis_pkg::BYTE_W-1:0];
                end
            end
            amis_pkg::OP_MOVF:
            begin
                psw_next[amis_pkg::ST_Z] = (fval == '0);
                if (dbit)
                begin
                    wr    = 1'b1;
                    wdata = fval;
                end
                else
                begin
                    w_next = fval;
                end
            end
            [amis_pkg::OP_BCF_LO:amis_pkg::OP_BCF_HI]:
            begin
                wr    = 1'b1;
                wdata = fval & ~bit_mask;
            end
            [amis_pkg::OP_BSF_LO:amis_pkg::OP_BSF_HI]:
            begin
                wr    = 1'b1;
                wdata = fval | bit_mask;
            end
            [amis_pkg::OP_GOTO_LO:amis_pkg::OP_GOTO_HI]:
            begin
                pc_next = goto_ext[PC_WIDTH-1:0];
            end
            default:
            begin
                unsup = 1'b1;
            end
        endcase
    end

    // Data store: clearing pass or committed write, and the operand read.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (s1_fire && wr)
        begin
            mem[s1_addr_reg] <= wdata;
        end
        if (accept)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Clearing pass sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            if (clr_idx_reg == LAST_IDX)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Architectural state, execute stage control, forwarding valid and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= '0;
            psw_reg       <= amis_pkg::STATUS_RST;
            pc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                w_reg      <= w_next;
                psw_reg    <= psw_next;
                pc_reg     <= pc_next;
                if (wr)
                begin
                    fwd_valid_reg <= 1'b1;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the execute stage, forwarding and result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= instr_word;
            s1_addr_reg <= rd_addr;
        end
        if (s1_fire && wr)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= wdata;
        end
        if (s1_fire)
        begin
            pc_out_reg     <= amis_pkg::PC_OUT_W'(pc_next);
            w_out_reg      <= w_next;
            status_out_reg <= psw_next;
            wr_out_reg     <= wr;
            addr_out_reg   <= wr ? amis_pkg::MADDR_W'(s1_addr_reg) : '0;
            data_out_reg   <= wdata;
            unsup_out_reg  <= unsup;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = pc_out_reg;
    assign w_out       = w_out_reg;
    assign status_out  = status_out_reg;
    assign mem_write   = wr_out_reg;
    assign mem_addr    = addr_out_reg;
    assign mem_data    = data_out_reg;
    assign unsupported = unsup_out_reg;

endmodule

`default_nettype wire
